// ----- rtl/ipte_pkg.sv -----
// Shared types and constants for the IPv4/TCP payload extractor.
// No dependencies; imported by every module of the block.
`default_nettype none

package ipte_pkg;

   localparam int unsigned RSP_QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      EV_PAYLOAD   = 2'd0,
      EV_CLEAN     = 2'd1,
      EV_TRUNC     = 2'd2,
      EV_MALFORMED = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [7:0]     payload_byte;
      logic           payload_last;
      event_kind_type event_kind;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } push_type;

endpackage

`default_nettype wire

// ----- rtl/ipte_parse.sv -----
// Per-byte header parser: tracks packet position and header lengths,
// produces up to two results per accepted request. Depends on ipte_pkg.
`default_nettype none

module ipte_parse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_accept,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_last,
   output ipte_pkg::push_type     push
);
   import ipte_pkg::*;

   logic [15:0] pos_ff, pos_in;
   logic [5:0]  ihl_ff, ihl_in;
   logic [15:0] tot_ff, tot_in;
   logic [5:0]  tcp_ff, tcp_in;
   logic        halt_ff, halt_in;

   logic [6:0]  hdr_end;
   logic [6:0]  hdr_sum;
   logic [6:0]  hdr_min;
   logic [6:0]  hdr_new;
   logic [16:0] pos_nx;
   logic        bad;
   logic        pay;
   result_type  pay_res;
   result_type  end_res;

   always_comb begin
      ihl_in  = ihl_ff;
      tot_in  = tot_ff;
      tcp_in  = tcp_ff;
      pos_in  = pos_ff;
      halt_in = halt_ff;
      bad     = 1'b0;
      pay     = 1'b0;
      hdr_end = {1'b0, ihl_ff} + 7'd12;
      hdr_sum = {1'b0, ihl_ff} + {1'b0, tcp_ff};
      hdr_min = {1'b0, ihl_ff} + 7'd20;
      hdr_new = 7'd0;
      pos_nx  = {1'b0, pos_ff} + 17'd1;
      push    = '0;
      pay_res = '0;
      end_res = '0;
      if (in_accept && !halt_ff) begin
         if (pos_ff == 16'd0) begin
            ihl_in = {in_byte[3:0], 2'b00};
            bad    = (ihl_in < 6'd20);
         end else if (pos_ff == 16'd2) begin
            tot_in = {in_byte, 8'h00};
         end else if (pos_ff == 16'd3) begin
            tot_in = {tot_ff[15:8], in_byte};
            bad    = (tot_in < {9'd0, hdr_min});
         end else if (pos_ff > 16'd3 && pos_ff == {9'd0, hdr_end}) begin
            tcp_in  = {in_byte[7:4], 2'b00};
            hdr_new = {1'b0, ihl_ff} + {1'b0, tcp_in};
            bad     = (tcp_in < 6'd20) || (tot_ff < {9'd0, hdr_new});
         end else if (pos_ff > {9'd0, hdr_end} && pos_ff >= {9'd0, hdr_sum}) begin
            pay = 1'b1;
         end

         pay_res.payload_byte = in_byte;
         pay_res.payload_last = (pos_nx == {1'b0, tot_in});
         pay_res.event_kind   = EV_PAYLOAD;

         if (pos_ff > 16'd3 && pos_nx == {1'b0, tot_in}) begin
            pos_in = 16'd0;
         end else begin
            pos_in = pos_nx[15:0];
         end

         end_res.payload_byte = 8'd0;
         end_res.payload_last = 1'b0;
         end_res.event_kind   = (pos_in == 16'd0) ? EV_CLEAN : EV_TRUNC;

         if (bad) begin
            halt_in                = 1'b1;
            pos_in                 = pos_ff;
            push.count             = 2'd1;
            push.res0.payload_byte = 8'd0;
            push.res0.payload_last = 1'b0;
            push.res0.event_kind   = EV_MALFORMED;
         end else if (pay) begin
            push.res0  = pay_res;
            push.res1  = end_res;
            push.count = in_last ? 2'd2 : 2'd1;
         end else begin
            push.res0  = end_res;
            push.count = in_last ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         ihl_ff  <= '0;
         tot_ff  <= '0;
         tcp_ff  <= '0;
         halt_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         ihl_ff  <= ihl_in;
         tot_ff  <= tot_in;
         tcp_ff  <= tcp_in;
         halt_ff <= halt_in;
      end
   end

   a_malformed_halts: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0 && push.res0.event_kind == EV_MALFORMED) |=> halt_ff)
      else $error("malformed header did not halt the parser");

   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> push.count == 2'd0)
      else $error("halted parser produced a result");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> (push.res0.event_kind == EV_PAYLOAD &&
                              (push.res1.event_kind == EV_CLEAN ||
                               push.res1.event_kind == EV_TRUNC)))
      else $error("two results not a payload byte followed by an end event");

endmodule

`default_nettype wire

// ----- rtl/ipte_rsp_queue.sv -----
// Small result queue taking up to two results per cycle, one out per cycle.
// Depends on ipte_pkg for the result and push types.
`default_nettype none

module ipte_rsp_queue #(
   parameter int unsigned DEPTH = ipte_pkg::RSP_QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ipte_pkg::push_type   push,
   input  wire logic                 pop,
   output ipte_pkg::result_type      head,
   output logic                      not_empty,
   output logic                      room_two
);
   import ipte_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FILL_MAX = CW'(DEPTH - 2);

   result_type    entry_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] wr_next;
   logic          do_pop;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
      wrap_inc = (p == LAST_IDX) ? '0 : p + PW'(1);
   endfunction

   assign not_empty = (cnt_ff != '0);
   assign room_two  = (cnt_ff <= FILL_MAX);
   assign head      = entry_ff[rd_ff];
   assign do_pop    = pop && not_empty;
   assign wr_next   = wrap_inc(wr_ff);

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      if (push.count == 2'd1) begin
         wr_in = wr_next;
      end else if (push.count == 2'd2) begin
         wr_in = wrap_inc(wr_next);
      end
      if (do_pop) begin
         rd_in = wrap_inc(rd_ff);
      end
      cnt_in = cnt_ff + CW'(push.count) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> (CW'(push.count) + cnt_ff) <= CW'(DEPTH))
      else $error("result queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("result queue count out of range");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> rd_ff != $past(rd_ff) || DEPTH == 1)
      else $error("pop did not advance read pointer");

endmodule

`default_nettype wire

// ----- rtl/ipv4_tcp_payload_extractor.sv -----
// IPv4/TCP payload extractor top level: parser plus result queue.
// Results are written into the result queue when their request is accepted
// and offered from its head. Throughput: one request per cycle while the
// queue has room for two; an end-of-log payload byte yields two results.
// Reset clears position, header lengths and the halt flag, and empties the
// queue; after a malformed header the block stays halted until reset.
`default_nettype none

module ipv4_tcp_payload_extractor #(
   parameter int unsigned RSP_DEPTH = ipte_pkg::RSP_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] log_byte
   input  wire logic        req_tlast,   // end_of_log
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] payload_byte
   output logic             rsp_tlast,   // payload_last
   output logic [1:0]       rsp_tuser    // [1:0] event_kind
);
   import ipte_pkg::*;

   push_type   push;
   result_type head;
   logic       not_empty;
   logic       room_two;
   logic       req_accept;

   assign req_tready = room_two;
   assign req_accept = req_tvalid && room_two;

   ipte_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .push      (push)
   );

   ipte_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_tready),
      .head      (head),
      .not_empty (not_empty),
      .room_two  (room_two)
   );

   assign rsp_tvalid = not_empty;
   assign rsp_tdata  = head.payload_byte;
   assign rsp_tlast  = head.payload_last;
   assign rsp_tuser  = head.event_kind;

   a_no_push_unaccepted: assert property (@(posedge clock) disable iff (reset)
      !req_accept |-> push.count == 2'd0)
      else $error("result produced without an accepted request");

   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser == EV_PAYLOAD)
      else $error("last mark on a status event");

   a_event_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != EV_PAYLOAD) |-> rsp_tdata == 8'd0)
      else $error("status event carries data");

endmodule

`default_nettype wire
